>>> rtl/hic_pkg.sv
// Shared types and constants for the homography inlier counter.
// Used by the channel interfaces, the front queue, the back engine and the top level.
// No dependencies.
package hic_pkg;

  // Field widths
  localparam int PtW     = 12;              // pixel coordinate
  localparam int BitW    = $clog2(PtW);     // bit index into a coordinate
  localparam int CoefW   = 48;              // Q23.24 coefficient
  localparam int CntW    = 13;              // inlier count
  localparam int NumCoefs = 8;
  localparam int IdxW    = $clog2(NumCoefs);

  // Datapath widths: projected values fit 62 bits signed, errors 76 bits signed
  localparam int AccW    = 62;
  localparam int ErrW    = 76;
  localparam int LimW    = 66;

  localparam int DefMaxPairs  = 4096;
  localparam int DefQueueDepth = 2;

  // 1.0 in Q.24, the fixed h22 term
  localparam logic signed [AccW-1:0] OneQ24 = AccW'(64'sd16777216);
  localparam logic [CoefW-1:0]       CoefOne = CoefW'(64'd16777216);

  // Register indexes
  typedef enum logic [IdxW-1:0] {
    RegH00 = 3'd0,
    RegH01 = 3'd1,
    RegH02 = 3'd2,
    RegH10 = 3'd3,
    RegH11 = 3'd4,
    RegH12 = 3'd5,
    RegH20 = 3'd6,
    RegH21 = 3'd7
  } reg_idx_t;

  typedef logic [NumCoefs-1:0][CoefW-1:0] coef_set_t;

  // One queued point pair
  typedef struct packed {
    logic [PtW-1:0] src_x;
    logic [PtW-1:0] src_y;
    logic [PtW-1:0] dst_x;
    logic [PtW-1:0] dst_y;
    logic           last_pair;
  } pair_t;

  // Back engine sequencer
  typedef enum logic [2:0] {
    StIdle,
    StProj,
    StProjFin,
    StTest,
    StSub,
    StAbs,
    StDone
  } st_t;

  typedef struct packed {
    logic load;      // pop a pair and clear accumulators
    logic proj;      // one bit step of the projection
    logic proj_fin;  // add translation terms
    logic test;      // one bit step of dst*w
    logic sub;       // subtract projection, form threshold
    logic absv;      // take magnitudes
    logic fire;      // compare, count, write result register
  } ctl_t;

endpackage

>>> rtl/hic_if.sv
// Valid/ready channel interfaces for point pairs in and results out.
// Depends on hic_pkg.
interface hic_in_if
  import hic_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [PtW-1:0] src_x;
  logic [PtW-1:0] src_y;
  logic [PtW-1:0] dst_x;
  logic [PtW-1:0] dst_y;
  logic           last_pair;

  modport source (output valid, src_x, src_y, dst_x, dst_y, last_pair, input ready);
  modport sink   (input valid, src_x, src_y, dst_x, dst_y, last_pair, output ready);
endinterface

interface hic_out_if
  import hic_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            is_inlier;
  logic [CntW-1:0] inlier_total;
  logic            set_done;

  modport source (output valid, is_inlier, inlier_total, set_done, input ready);
  modport sink   (input valid, is_inlier, inlier_total, set_done, output ready);
endinterface

>>> rtl/hic_front.sv
// Front end: accepts point pair beats and holds them in a short queue.
// Depends on hic_pkg and hic_in_if.
module hic_front
  import hic_pkg::*;
#(
  parameter int DEPTH = DefQueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  hic_in_if.sink     in_pair,
  input  logic       pop,
  output logic       q_valid,
  output pair_t      q_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntQW = $clog2(DEPTH + 1);

  pair_t             mem_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntQW-1:0]  fill_r;
  logic              push;

  assign in_pair.ready = (fill_r != CntQW'(DEPTH));
  assign push          = in_pair.valid && in_pair.ready;
  assign q_valid       = (fill_r != '0);
  assign q_data        = mem_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{src_x:     in_pair.src_x,
                           src_y:     in_pair.src_y,
                           dst_x:     in_pair.dst_x,
                           dst_y:     in_pair.dst_y,
                           last_pair: in_pair.last_pair};
    end
  end

endmodule

>>> rtl/hic_back.sv
// Back end: bit-serial projection and axis test, inlier count, result register.
// Depends on hic_pkg and hic_out_if.
module hic_back
  import hic_pkg::*;
#(
  parameter int MAX_PAIRS = DefMaxPairs
) (
  input  logic       clk,
  input  logic       rst_n,
  input  coef_set_t  coefs,
  input  logic       q_valid,
  input  pair_t      q_data,
  output logic       pop,
  hic_out_if.source  out_res
);

  localparam int CapInt = (MAX_PAIRS < 8191) ? MAX_PAIRS : 8191;
  localparam logic [CntW-1:0] CountCap = CntW'(CapInt);
  localparam logic [BitW-1:0] BitTop   = BitW'(PtW - 1);

  st_t  st_r, st_nxt;
  ctl_t ctl;

  pair_t                  pair_r;
  logic [BitW-1:0]        bit_r;
  logic signed [AccW-1:0] xp_r, yp_r, w_r;
  logic signed [ErrW-1:0] dx_r, dy_r;
  logic [AccW-1:0]        wabs_r;
  logic [LimW-1:0]        lim_r;
  logic [CntW-1:0]        cnt_r;

  logic                   out_valid_r;
  logic                   is_inlier_r, set_done_r;
  logic [CntW-1:0]        total_r;

  logic                   slot_free;
  logic signed [AccW-1:0] h00, h01, h02, h10, h11, h12, h20, h21;
  logic signed [ErrW-1:0] w_ext;
  logic                   hit;
  logic [CntW-1:0]        cnt_new;

  assign slot_free = !out_valid_r || out_res.ready;

  // Coefficients sign-extended to accumulator width
  assign h00 = AccW'($signed(coefs[RegH00]));
  assign h01 = AccW'($signed(coefs[RegH01]));
  assign h02 = AccW'($signed(coefs[RegH02]));
  assign h10 = AccW'($signed(coefs[RegH10]));
  assign h11 = AccW'($signed(coefs[RegH11]));
  assign h12 = AccW'($signed(coefs[RegH12]));
  assign h20 = AccW'($signed(coefs[RegH20]));
  assign h21 = AccW'($signed(coefs[RegH21]));
  assign w_ext = ErrW'(w_r);

  // Sequencer next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      StIdle:    if (q_valid) st_nxt = StProj;
      StProj:    if (bit_r == '0) st_nxt = StProjFin;
      StProjFin: st_nxt = StTest;
      StTest:    if (bit_r == '0) st_nxt = StSub;
      StSub:     st_nxt = StAbs;
      StAbs:     st_nxt = StDone;
      StDone:    if (slot_free) st_nxt = StIdle;
      default:   st_nxt = StIdle;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ctl = '0;
    unique case (st_r)
      StIdle:    ctl.load     = q_valid;
      StProj:    ctl.proj     = 1'b1;
      StProjFin: ctl.proj_fin = 1'b1;
      StTest:    ctl.test     = 1'b1;
      StSub:     ctl.sub      = 1'b1;
      StAbs:     ctl.absv     = 1'b1;
      StDone:    ctl.fire     = slot_free;
      default:   ctl = '0;
    endcase
  end

  assign pop = ctl.load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Datapath: MSB-first shift-add over the 12 coordinate bits
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pair_r <= q_data;
      bit_r  <= BitTop;
      xp_r   <= '0;
      yp_r   <= '0;
      w_r    <= '0;
    end
    if (ctl.proj) begin
      xp_r  <= (xp_r <<< 1) + (pair_r.src_x[bit_r] ? h00 : '0)
                            + (pair_r.src_y[bit_r] ? h01 : '0);
      yp_r  <= (yp_r <<< 1) + (pair_r.src_x[bit_r] ? h10 : '0)
                            + (pair_r.src_y[bit_r] ? h11 : '0);
      w_r   <= (w_r <<< 1)  + (pair_r.src_x[bit_r] ? h20 : '0)
                            + (pair_r.src_y[bit_r] ? h21 : '0);
      bit_r <= bit_r - 1'b1;
    end
    if (ctl.proj_fin) begin
      xp_r  <= xp_r + h02;
      yp_r  <= yp_r + h12;
      w_r   <= w_r + OneQ24;
      dx_r  <= '0;
      dy_r  <= '0;
      bit_r <= BitTop;
    end
    if (ctl.test) begin
      dx_r   <= (dx_r <<< 1) + (pair_r.dst_x[bit_r] ? w_ext : '0);
      dy_r   <= (dy_r <<< 1) + (pair_r.dst_y[bit_r] ? w_ext : '0);
      wabs_r <= w_r[AccW-1] ? AccW'(-w_r) : AccW'(w_r);
      bit_r  <= bit_r - 1'b1;
    end
    if (ctl.sub) begin
      dx_r  <= dx_r - ErrW'(xp_r);
      dy_r  <= dy_r - ErrW'(yp_r);
      // 10*|w| = 8*|w| + 2*|w|
      lim_r <= (LimW'(wabs_r) << 3) + (LimW'(wabs_r) << 1);
    end
    if (ctl.absv) begin
      dx_r <= dx_r[ErrW-1] ? -dx_r : dx_r;
      dy_r <= dy_r[ErrW-1] ? -dy_r : dy_r;
    end
  end

  // Strict test on magnitudes; zero w gives a zero limit and never hits
  assign hit     = (ErrW'(dx_r) < ErrW'(lim_r)) && (ErrW'(dy_r) < ErrW'(lim_r));
  assign cnt_new = (hit && (cnt_r < CountCap)) ? cnt_r + 1'b1 : cnt_r;

  // Running count, clears after the last pair of a set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.fire) begin
      cnt_r <= pair_r.last_pair ? '0 : cnt_new;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      is_inlier_r <= hit;
      total_r     <= cnt_new;
      set_done_r  <= pair_r.last_pair;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.is_inlier    = is_inlier_r;
  assign out_res.inlier_total = total_r;
  assign out_res.set_done     = set_done_r;

endmodule

>>> rtl/homography_inlier_counter_top.sv
// Homography inlier counter: per-pair sequence. The back engine loads each point pair,
// takes 12 bit-serial steps forming xp, yp and w, adds the translation terms,
// takes 12 bit-serial steps forming dst*w on both axes, then subtracts, takes
// magnitudes and compares/counts. The shift-add datapath works on one bit of the
// 12-bit coordinates per cycle. A two-beat queue in front keeps accepting pairs
// while the engine works, and a result register lets the engine work on the next
// pair while a result waits. The coefficient registers reset to the identity
// homography and are written through cfg_we / cfg_idx / cfg_wdata; the user must
// write them only while the block is idle, as the block itself does not enforce it.
//
// Top level: coefficient registers, front queue and back engine.
// Depends on hic_pkg, hic_if, hic_front and hic_back.
module homography_inlier_counter_top
  import hic_pkg::*;
#(
  parameter int MAX_PAIRS = DefMaxPairs
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IdxW-1:0]  cfg_idx,
  input  logic [CoefW-1:0] cfg_wdata,
  hic_in_if.sink           in_pair,
  hic_out_if.source        out_res
);

  coef_set_t coef_r;
  coef_set_t coef_rst;
  logic      q_valid;
  pair_t     q_data;
  logic      pop;

  // Identity homography loaded at reset
  always_comb begin
    coef_rst         = '0;
    coef_rst[RegH00] = CoefOne;
    coef_rst[RegH11] = CoefOne;
  end

  // Coefficient registers, identity after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= coef_rst;
    end else if (cfg_we) begin
      coef_r[cfg_idx] <= cfg_wdata;
    end
  end

  hic_front #(
    .DEPTH (DefQueueDepth)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pair (in_pair),
    .pop     (pop),
    .q_valid (q_valid),
    .q_data  (q_data)
  );

  hic_back #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .coefs   (coef_r),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule

>>> test/homography_inlier_counter_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for homography_inlier_counter_top: drives point pairs through
// random idling, predicts each verdict and running count, and checks every result beat.
// Depends on hic_pkg, hic_if and the homography_inlier_counter_top RTL.
module homography_inlier_counter_top_test;
  import hic_pkg::*;

  localparam int          CountCap   = (DefMaxPairs < 8191) ? DefMaxPairs : 8191;
  localparam int          LongSet    = 256;
  localparam int          QuietLimit = 2000;
  localparam longint      OnePx      = 64'sd16777216;
  localparam logic signed [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic signed [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};

  typedef logic signed [127:0] wide_t;
  typedef logic signed [CoefW-1:0] coef_arr_t [NumCoefs];

  typedef struct packed {
    logic            is_inlier;
    logic [CntW-1:0] inlier_total;
    logic            set_done;
  } verdict_t;

  typedef struct {
    pair_t       beat;
    int unsigned gap;
  } pend_t;

  typedef enum int { IdleNone, IdleFull, IdleBursty } idle_mode_t;
  typedef enum int {
    HgIdentity, HgAffine, HgPerspective, HgSteep, HgRandom, HgMaxAll, HgMinAll, HgMixed
  } hg_kind_t;

  // Clock and reset
  logic clk;
  logic rst_n = 1'b0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Configuration port
  logic             cfg_we    = 1'b0;
  logic [IdxW-1:0]  cfg_idx   = '0;
  logic [CoefW-1:0] cfg_wdata = '0;

  hic_in_if  in_pair ();
  hic_out_if out_res ();

  // Bench-side drive registers, known from time zero
  logic  drv_valid = 1'b0;
  pair_t drv_beat  = '0;
  logic  rcv_ready = 1'b0;

  assign in_pair.valid     = drv_valid;
  assign in_pair.src_x     = drv_beat.src_x;
  assign in_pair.src_y     = drv_beat.src_y;
  assign in_pair.dst_x     = drv_beat.dst_x;
  assign in_pair.dst_y     = drv_beat.dst_y;
  assign in_pair.last_pair = drv_beat.last_pair;
  assign out_res.ready     = rcv_ready;

  homography_inlier_counter_top #(
    .MAX_PAIRS(DefMaxPairs)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_pair  (in_pair),
    .out_res  (out_res)
  );

  // Shadow state
  coef_arr_t       coef_m;
  logic [CntW-1:0] tally = '0;

  pend_t      pairs_to_send [$];
  verdict_t   verdicts_due [$];
  idle_mode_t idle_mode = IdleFull;
  logic       in_took   = 1'b0;
  logic       out_took  = 1'b0;
  int         err_cnt   = 0;
  int         quiet_cyc = 0;
  int unsigned gap_cnt   = 0;
  int unsigned stall_cnt = 0;

  hg_kind_t phase_plan [12] = '{HgAffine, HgPerspective, HgIdentity, HgSteep,
                                HgRandom, HgAffine, HgPerspective, HgMaxAll,
                                HgSteep, HgMinAll, HgMixed, HgPerspective};

  function automatic int unsigned pause_len();
    case (idle_mode)
      IdleNone:   return 0;
      IdleBursty: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : 0;
      default:    return $urandom_range(0, 17);
    endcase
  endfunction

  function automatic coef_arr_t identity_h();
    coef_arr_t h;
    foreach (h[i]) h[i] = '0;
    h[RegH00] = CoefOne;
    h[RegH11] = CoefOne;
    return h;
  endfunction

  function automatic wide_t wide_abs(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // Projection in Q.24: xp, yp and w are exact
  function automatic void project(input logic [PtW-1:0] sx, input logic [PtW-1:0] sy,
                                  output wide_t xp, output wide_t yp, output wide_t w);
    wide_t x, y;
    x  = $signed({116'd0, sx});
    y  = $signed({116'd0, sy});
    xp = coef_m[RegH00] * x + coef_m[RegH01] * y + coef_m[RegH02];
    yp = coef_m[RegH10] * x + coef_m[RegH11] * y + coef_m[RegH12];
    w  = coef_m[RegH20] * x + coef_m[RegH21] * y + $signed({80'd0, CoefOne});
  endfunction

  // Division-free axis test and saturating running count
  function automatic verdict_t score_pair(input pair_t p);
    wide_t    xp, yp, w, ex, ey, lim;
    logic     hit;
    verdict_t v;
    project(p.src_x, p.src_y, xp, yp, w);
    ex  = $signed({116'd0, p.dst_x}) * w - xp;
    ey  = $signed({116'd0, p.dst_y}) * w - yp;
    lim = 10 * wide_abs(w);
    hit = (w != 0) && (wide_abs(ex) < lim) && (wide_abs(ey) < lim);
    if (hit && tally < CountCap) tally = tally + 1'b1;
    v.is_inlier    = hit;
    v.inlier_total = tally;
    v.set_done     = p.last_pair;
    if (p.last_pair) tally = '0;
    return v;
  endfunction

  function automatic void flag_error(input string what);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t ERROR: %s", $time, what);
  endfunction

  // Stimulus helpers
  function automatic logic [PtW-1:0] pick_px();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PtW'($urandom);
    endcase
  endfunction

  function automatic logic [PtW-1:0] near_px(input wide_t proj, input int unsigned spread);
    wide_t v;
    v = proj + wide_t'($urandom_range(0, 2 * spread)) - wide_t'(spread);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return v[PtW-1:0];
  endfunction

  // Target near the projected point, so that many pairs pass
  function automatic void aim_at(input logic [PtW-1:0] sx, input logic [PtW-1:0] sy,
                                 input int unsigned spread,
                                 output logic [PtW-1:0] dx, output logic [PtW-1:0] dy);
    wide_t xp, yp, w;
    project(sx, sy, xp, yp, w);
    if (w == 0) begin
      dx = PtW'($urandom);
      dy = PtW'($urandom);
    end else begin
      dx = near_px(xp / w, spread);
      dy = near_px(yp / w, spread);
    end
  endfunction

  function automatic void queue_pair(input logic [PtW-1:0] sx, input logic [PtW-1:0] sy,
                                     input logic [PtW-1:0] dx, input logic [PtW-1:0] dy,
                                     input logic last);
    pend_t p;
    p.beat = '{src_x: sx, src_y: sy, dst_x: dx, dst_y: dy, last_pair: last};
    p.gap  = pause_len();
    pairs_to_send.insert(pairs_to_send.size(), p);
  endfunction

  function automatic logic signed [CoefW-1:0] spread(input int unsigned m);
    return CoefW'(longint'($urandom_range(0, 2 * m)) - longint'(m));
  endfunction

  function automatic logic signed [CoefW-1:0] shift_px(input int unsigned m);
    return CoefW'(((longint'($urandom_range(0, 2 * m)) - longint'(m)) <<< 24) +
                  longint'($urandom_range(0, 24'hFFFFFF)));
  endfunction

  // Wait until the block is idle: nothing queued, nothing in flight
  task automatic settle();
    while (pairs_to_send.size() != 0 || drv_valid || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_homography(input coef_arr_t h);
    settle();
    for (int i = 0; i < NumCoefs; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= reg_idx_t'(i);
      cfg_wdata <= h[i];
      coef_m[i] = h[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_homography(input hg_kind_t kind);
    coef_arr_t h;
    h = identity_h();
    case (kind)
      HgAffine, HgPerspective, HgSteep: begin
        h[RegH00] = h[RegH00] + spread(1 << 23);
        h[RegH01] = spread(1 << 22);
        h[RegH02] = shift_px(600);
        h[RegH10] = spread(1 << 22);
        h[RegH11] = h[RegH11] + spread(1 << 23);
        h[RegH12] = shift_px(600);
        if (kind == HgPerspective) begin
          h[RegH20] = spread(1 << 11);
          h[RegH21] = spread(1 << 11);
        end else if (kind == HgSteep) begin
          h[RegH20] = spread(1 << 14);
          h[RegH21] = spread(1 << 14);
        end
      end
      HgRandom: foreach (h[i]) h[i] = CoefW'({$urandom, $urandom});
      HgMaxAll: foreach (h[i]) h[i] = CoefMax;
      HgMinAll: foreach (h[i]) h[i] = CoefMin;
      HgMixed: begin
        foreach (h[i]) begin
          case ($urandom_range(0, 3))
            0:       h[i] = CoefMax;
            1:       h[i] = CoefMin;
            2:       h[i] = '0;
            default: h[i] = CoefOne;
          endcase
        end
      end
      default: ;
    endcase
    write_homography(h);
  endtask

  // Sets of random length; mostly targets aimed at the projection
  task automatic queue_sets(input int unsigned n_items);
    int unsigned    left_in_set;
    int unsigned    roll;
    logic [PtW-1:0] sx, sy, dx, dy;
    left_in_set = 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (left_in_set == 0)
        left_in_set = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
      sx   = pick_px();
      sy   = pick_px();
      roll = $urandom_range(0, 9);
      if (roll < 6) aim_at(sx, sy, 8, dx, dy);
      else if (roll < 8) aim_at(sx, sy, 30, dx, dy);
      else begin
        dx = PtW'($urandom);
        dy = PtW'($urandom);
      end
      left_in_set--;
      queue_pair(sx, sy, dx, dy, left_in_set == 0);
    end
  endtask

  // Input driver: a beat holds until taken, then the next one waits its gap
  always @(negedge clk) begin : sender
    pend_t nxt;
    if (!rst_n) begin
      drv_valid <= 1'b0;
      gap_cnt   <= 0;
    end else if (drv_valid && !in_took) begin
      // hold the beat
    end else if (pairs_to_send.size() != 0 && gap_cnt >= pairs_to_send[0].gap) begin
      nxt = pairs_to_send.pop_front();
      drv_beat  <= nxt.beat;
      drv_valid <= 1'b1;
      gap_cnt   <= 0;
    end else begin
      drv_valid <= 1'b0;
      if (pairs_to_send.size() != 0) gap_cnt <= gap_cnt + 1;
    end
  end

  // Result receiver: after each beat, stall for a random pause drawn by the idle mode
  always @(negedge clk) begin : receiver
    int unsigned left;
    if (!rst_n) begin
      rcv_ready <= 1'b0;
      stall_cnt = 0;
    end else begin
      left = stall_cnt;
      if (out_took) left = pause_len();
      if (left > 0) begin
        rcv_ready <= 1'b0;
        stall_cnt = left - 1;
      end else begin
        rcv_ready <= 1'b1;
        stall_cnt = 0;
      end
    end
  end

  // Predict on each accepted pair, check each accepted result
  always @(posedge clk) begin : scoreboard
    verdict_t want, got;
    pair_t    seen;
    in_took  = rst_n && in_pair.valid && in_pair.ready;
    out_took = rst_n && out_res.valid && out_res.ready;
    if (out_took) begin
      got.is_inlier    = out_res.is_inlier;
      got.inlier_total = out_res.inlier_total;
      got.set_done     = out_res.set_done;
      if (verdicts_due.size() == 0) begin
        flag_error($sformatf("unexpected result: inlier=%0d total=%0d done=%0d",
                             got.is_inlier, got.inlier_total, got.set_done));
      end else begin
        want = verdicts_due.pop_front();
        if (want.is_inlier !== got.is_inlier || want.inlier_total !== got.inlier_total ||
            want.set_done !== got.set_done)
          flag_error($sformatf({"result mismatch: expected inlier=%0d total=%0d done=%0d,",
                                " got inlier=%0d total=%0d done=%0d"},
                               want.is_inlier, want.inlier_total, want.set_done,
                               got.is_inlier, got.inlier_total, got.set_done));
      end
    end
    if (in_took) begin
      seen = '{src_x: in_pair.src_x, src_y: in_pair.src_y,
               dst_x: in_pair.dst_x, dst_y: in_pair.dst_y,
               last_pair: in_pair.last_pair};
      verdicts_due.insert(verdicts_due.size(), score_pair(seen));
    end
  end

  // Watchdog on cycles with no beat and no register write
  always @(posedge clk) begin : watchdog
    if ((in_pair.valid && in_pair.ready) || (out_res.valid && out_res.ready) || cfg_we)
      quiet_cyc = 0;
    else
      quiet_cyc++;
    if (quiet_cyc >= QuietLimit) begin
      $display("%0t timeout: no beat for %0d cycles", $time, QuietLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    coef_arr_t h;
    coef_m = identity_h();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset homography (identity): corners, threshold edges, set end
    queue_pair(12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_pair(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0);
    queue_pair(12'd0, 12'd0, 12'd9, 12'd9, 1'b0);
    queue_pair(12'd100, 12'd100, 12'd110, 12'd100, 1'b0);
    queue_pair(12'd100, 12'd100, 12'd91, 12'd109, 1'b0);
    queue_pair(12'd4095, 12'd0, 12'd0, 12'd4095, 1'b1);
    queue_pair(12'd2048, 12'd1024, 12'd2048, 12'd1024, 1'b1);

    // w = 1 - x: zero w at x = 1, negative w beyond
    h = identity_h();
    h[RegH20] = -CoefW'(OnePx);
    write_homography(h);
    queue_pair(12'd1, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_pair(12'd1, 12'd4095, 12'd4095, 12'd4095, 1'b0);
    queue_pair(12'd2, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_pair(12'd2, 12'd0, 12'd5, 12'd0, 1'b1);

    // Largest positive coefficients everywhere
    foreach (h[i]) h[i] = CoefMax;
    write_homography(h);
    queue_pair(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0);
    queue_pair(12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_pair(12'd4095, 12'd0, 12'd0, 12'd4095, 1'b1);

    // Most negative coefficients everywhere
    foreach (h[i]) h[i] = CoefMin;
    write_homography(h);
    queue_pair(12'd4095, 12'd4095, 12'd0, 12'd0, 1'b0);
    queue_pair(12'd0, 12'd4095, 12'd4095, 12'd0, 1'b0);
    queue_pair(12'd0, 12'd0, 12'd4095, 12'd4095, 1'b1);

    // Translation just inside the threshold on x, exactly on it on y
    h = identity_h();
    h[RegH02] = CoefW'(10 * OnePx - 1);
    h[RegH12] = CoefW'(10 * OnePx);
    write_homography(h);
    queue_pair(12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    queue_pair(12'd0, 12'd0, 12'd0, 12'd1, 1'b0);
    queue_pair(12'd0, 12'd0, 12'd20, 12'd20, 1'b1);

    // One long set of inliers to run the count up, no idling
    write_homography(identity_h());
    idle_mode = IdleNone;
    for (int i = 0; i < LongSet; i++) begin
      logic [PtW-1:0] px, py;
      px = PtW'($urandom);
      py = PtW'($urandom);
      queue_pair(px, py, px, py, i == LongSet - 1);
    end

    // Random phases, each with its own homography and idling style
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        1:       idle_mode = IdleBursty;
        3:       idle_mode = IdleNone;
        default: idle_mode = IdleFull;
      endcase
      load_homography(phase_plan[ph]);
      queue_sets(60);
      if (ph == 2) settle();
      queue_sets(60);
    end

    settle();
    repeat (40) @(posedge clk);
    if (verdicts_due.size() != 0)
      flag_error($sformatf("%0d results never arrived", verdicts_due.size()));
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
